>>> sv/gfvl_pkg.sv
package gfvl_pkg;

  localparam int unsigned FINGER_COUNT_DEF = 3;

  localparam int unsigned CMD_W    = 3;
  localparam int unsigned FINGER_W = 2;
  localparam int unsigned FORCE_W  = 12;
  localparam int unsigned POS_W    = 18;
  localparam int unsigned WEIGHT_W = 14;
  localparam int unsigned VEL_W    = 17;
  localparam int unsigned CFG_AW   = 1;
  localparam int unsigned CFG_DW   = 18;

  // Q8 ratio: quotient bits produced by the divider
  localparam int unsigned FRAC_W  = 8;
  localparam int unsigned RATIO_W = FRAC_W + 1;
  localparam int unsigned STEP_W  = $clog2(FRAC_W);

  localparam logic [CMD_W-1:0] CMD_OPEN    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_CLOSE   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_STOP    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_HOLD    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CAPTURE = 3'd4;

  localparam logic [CFG_AW-1:0] REG_GRASP_THR = 1'd0;
  localparam logic [CFG_AW-1:0] REG_OPEN_STOP = 1'd1;

  localparam logic [FORCE_W-1:0] GRASP_THR_RST = 12'd400;
  localparam logic [POS_W-1:0]   OPEN_STOP_RST = 18'd28444;

  localparam logic [RATIO_W-1:0] RATIO_ONE = 9'd256;

  // weight / 5 via reciprocal: floor(x * 1639 >> 13) is exact for x < 1280
  localparam logic [WEIGHT_W-1:0] WS_SAT    = 14'd1280;
  localparam int unsigned         WS_MAG_W  = 11;
  localparam logic [WS_MAG_W-1:0] WS_RECIP  = 11'd1639;
  localparam int unsigned         WS_SHIFT  = 13;

  localparam int unsigned      CALC_W         = VEL_W + 1;
  localparam logic [CALC_W-1:0] VEL_CLOSE_BASE = 18'd23040;
  localparam logic [CALC_W-1:0] VEL_OPEN_BASE  = -18'sd17920;
  localparam logic [CALC_W-1:0] GAIN_RATIO     = 18'd50;
  localparam logic [CALC_W-1:0] GAIN_WS_CLOSE  = 18'd40;
  localparam logic [CALC_W-1:0] GAIN_WS_OPEN   = 18'd50;

endpackage

>>> sv/gfvl_div.sv
module gfvl_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [gfvl_pkg::FORCE_W-1:0]  num_i,
  input  logic [gfvl_pkg::FORCE_W-1:0]  den_i,
  output logic                          done_o,
  output logic [gfvl_pkg::FRAC_W-1:0]   quot_o
);

  // floor(num * 2^FRAC_W / den), num < den, one quotient bit per cycle
  logic                          busy_q;
  logic                          done_q;
  logic [gfvl_pkg::STEP_W-1:0]   cnt_q;
  logic [gfvl_pkg::FORCE_W-1:0]  rem_q, rem_d;
  logic [gfvl_pkg::FORCE_W-1:0]  den_q;
  logic [gfvl_pkg::FRAC_W-1:0]   quot_q;
  logic [gfvl_pkg::FORCE_W:0]    trial;
  logic                          qbit;

  always_comb begin
    trial = {rem_q, 1'b0};
    qbit  = trial >= {1'b0, den_q};
    rem_d = qbit ? gfvl_pkg::FORCE_W'(trial - {1'b0, den_q})
                 : trial[gfvl_pkg::FORCE_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == gfvl_pkg::STEP_W'(gfvl_pkg::FRAC_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q  <= rem_d;
      quot_q <= {quot_q[gfvl_pkg::FRAC_W-2:0], qbit};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

>>> sv/gripper_finger_velocity_law_top.sv
// Finger velocity law for a multi-finger gripper.
// Input channel (in_valid_i / in_stall_o): one finger sample per transaction
// with command, finger index, force, position and weight estimate.
// Output channel (out_valid_o / out_stall_i): one transaction per sample with
// the finger index and the Q8 velocity commanded for it.
// Configuration: cfg_we_i writes cfg_wdata_i to register cfg_addr_i
// (0 grasp force threshold, 1 open-stop position); write only while idle.
// Timing: open and close samples whose force ratio lies strictly inside 0..1
// run the 8-step serial divider between the check and calc states; all other
// samples go straight from check to calc. in_stall_o stays high from accept
// until the calc state has loaded the result, so a new sample is accepted only
// after that. The result is registered; the block accepts the next sample
// while an earlier result still waits. If the receiver stalls and the output
// register is still full when a new result is ready, the block holds that
// result and keeps in_stall_o high until the register frees up.
// Reset clears all finger baselines and last velocities, loads the register
// reset values and empties the output register. No clearing pass is needed.
module gripper_finger_velocity_law_top #(
  parameter int unsigned FINGER_COUNT = gfvl_pkg::FINGER_COUNT_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [gfvl_pkg::CMD_W-1:0]          cmd_i,
  input  logic [gfvl_pkg::FINGER_W-1:0]       finger_i,
  input  logic [gfvl_pkg::FORCE_W-1:0]        force_req_i,
  input  logic [gfvl_pkg::POS_W-1:0]          position_i,
  input  logic signed [gfvl_pkg::WEIGHT_W-1:0] weight_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [gfvl_pkg::FINGER_W-1:0]       finger_out_o,
  output logic signed [gfvl_pkg::VEL_W-1:0]   velocity_o,
  input  logic                                cfg_we_i,
  input  logic [gfvl_pkg::CFG_AW-1:0]         cfg_addr_i,
  input  logic [gfvl_pkg::CFG_DW-1:0]         cfg_wdata_i
);

  localparam int unsigned IDX_W = (FINGER_COUNT > 1) ? $clog2(FINGER_COUNT) : 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_CALC
  } state_e;

  state_e state_q;

  logic [gfvl_pkg::FORCE_W-1:0] thr_q;
  logic [gfvl_pkg::POS_W-1:0]   open_stop_q;
  logic [gfvl_pkg::FORCE_W-1:0] baseline_q [FINGER_COUNT];
  logic [gfvl_pkg::VEL_W-1:0]   last_vel_q [FINGER_COUNT];

  logic [gfvl_pkg::CMD_W-1:0]    cmd_q;
  logic [gfvl_pkg::FINGER_W-1:0] finger_q;
  logic [IDX_W-1:0]              idx_q;
  logic                          fin_ok_q;
  logic                          pos_ge_q;
  logic [gfvl_pkg::FORCE_W:0]    diff_q;
  logic [gfvl_pkg::RATIO_W-1:0]  ws_q;
  logic [gfvl_pkg::RATIO_W-1:0]  ratio_q;

  logic                          out_valid_q;
  logic [gfvl_pkg::FINGER_W-1:0] finger_out_q;
  logic [gfvl_pkg::VEL_W-1:0]    velocity_q;

  logic                          accept;
  logic [IDX_W-1:0]              idx_in;
  logic                          fin_ok_in;
  logic [gfvl_pkg::FORCE_W:0]    diff_in;
  logic [gfvl_pkg::WEIGHT_W:0]   w_ext;
  logic [gfvl_pkg::WEIGHT_W:0]   w_abs;
  logic                          ws_sign_ok;
  logic [2*gfvl_pkg::WS_MAG_W-1:0] ws_prod;
  logic [gfvl_pkg::RATIO_W-1:0]  ws_in;

  logic                          diff_pos;
  logic                          diff_ge;
  logic                          is_drive;
  logic                          need_div;
  logic                          div_done;
  logic [gfvl_pkg::FRAC_W-1:0]   div_quot;

  logic [gfvl_pkg::CALC_W-1:0]   p_ratio;
  logic [gfvl_pkg::CALC_W-1:0]   p_ws_close;
  logic [gfvl_pkg::CALC_W-1:0]   p_ws_open;
  logic [gfvl_pkg::CALC_W-1:0]   vel_close;
  logic [gfvl_pkg::CALC_W-1:0]   vel_open;
  logic [gfvl_pkg::VEL_W-1:0]    vel_d;
  logic                          store_vel;
  logic                          out_free;
  logic                          out_load;

  assign accept    = in_valid_i && (state_q == ST_IDLE);
  assign idx_in    = IDX_W'(finger_i);
  assign fin_ok_in = 32'(finger_i) < FINGER_COUNT;

  always_comb begin
    diff_in = {1'b0, force_req_i} - {1'b0, baseline_q[idx_in]};
    w_ext   = {weight_i[gfvl_pkg::WEIGHT_W-1], weight_i};
    w_abs   = w_ext[gfvl_pkg::WEIGHT_W] ? (~w_ext + 1'b1) : w_ext;
    ws_sign_ok = (cmd_i == gfvl_pkg::CMD_CLOSE) ? weight_i[gfvl_pkg::WEIGHT_W-1]
                                                : !weight_i[gfvl_pkg::WEIGHT_W-1];
    ws_prod = w_abs[gfvl_pkg::WS_MAG_W-1:0] * gfvl_pkg::WS_RECIP;
    if (!ws_sign_ok) begin
      ws_in = '0;
    end else if (w_abs >= {1'b0, gfvl_pkg::WS_SAT}) begin
      ws_in = gfvl_pkg::RATIO_ONE;
    end else begin
      ws_in = {1'b0, ws_prod[gfvl_pkg::WS_SHIFT +: gfvl_pkg::FRAC_W]};
    end
  end

  always_comb begin
    diff_pos = !diff_q[gfvl_pkg::FORCE_W] && (diff_q != '0);
    diff_ge  = $signed(diff_q) >= $signed({1'b0, thr_q});
    is_drive = (cmd_q == gfvl_pkg::CMD_OPEN) || (cmd_q == gfvl_pkg::CMD_CLOSE);
    need_div = fin_ok_q && is_drive && diff_pos && !diff_ge;
  end

  gfvl_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i ((state_q == ST_CHECK) && need_div),
    .num_i   (diff_q[gfvl_pkg::FORCE_W-1:0]),
    .den_i   (thr_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  always_comb begin
    p_ratio    = gfvl_pkg::CALC_W'(ratio_q) * gfvl_pkg::GAIN_RATIO;
    p_ws_close = gfvl_pkg::CALC_W'(ws_q) * gfvl_pkg::GAIN_WS_CLOSE;
    p_ws_open  = gfvl_pkg::CALC_W'(ws_q) * gfvl_pkg::GAIN_WS_OPEN;
    vel_close  = gfvl_pkg::VEL_CLOSE_BASE - p_ratio + p_ws_close;
    vel_open   = gfvl_pkg::VEL_OPEN_BASE - p_ratio - p_ws_open;
    vel_d      = '0;
    store_vel  = 1'b0;
    if (fin_ok_q) begin
      case (cmd_q)
        gfvl_pkg::CMD_OPEN: begin
          vel_d     = pos_ge_q ? vel_open[gfvl_pkg::VEL_W-1:0] : '0;
          store_vel = 1'b1;
        end
        gfvl_pkg::CMD_CLOSE: begin
          vel_d     = diff_ge ? '0 : vel_close[gfvl_pkg::VEL_W-1:0];
          store_vel = 1'b1;
        end
        gfvl_pkg::CMD_STOP: begin
          vel_d     = '0;
          store_vel = 1'b1;
        end
        default: begin
          vel_d = last_vel_q[idx_q];
        end
      endcase
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;
  assign out_load = (state_q == ST_CALC) && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      thr_q       <= gfvl_pkg::GRASP_THR_RST;
      open_stop_q <= gfvl_pkg::OPEN_STOP_RST;
      for (int i = 0; i < FINGER_COUNT; i++) begin
        baseline_q[i] <= '0;
        last_vel_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          gfvl_pkg::REG_GRASP_THR: thr_q       <= cfg_wdata_i[gfvl_pkg::FORCE_W-1:0];
          gfvl_pkg::REG_OPEN_STOP: open_stop_q <= cfg_wdata_i[gfvl_pkg::POS_W-1:0];
        endcase
      end
      if (out_valid_q && !out_stall_i && !out_load) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            if (fin_ok_in && (cmd_i == gfvl_pkg::CMD_CAPTURE)) begin
              baseline_q[idx_in] <= force_req_i;
            end
            state_q <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (need_div) begin
            state_q <= ST_DIV;
          end else begin
            ratio_q <= diff_pos ? gfvl_pkg::RATIO_ONE : '0;
            state_q <= ST_CALC;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            ratio_q <= {1'b0, div_quot};
            state_q <= ST_CALC;
          end
        end
        ST_CALC: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            finger_out_q <= finger_q;
            velocity_q   <= vel_d;
            if (store_vel) begin
              last_vel_q[idx_q] <= vel_d;
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q    <= cmd_i;
      finger_q <= finger_i;
      idx_q    <= idx_in;
      fin_ok_q <= fin_ok_in;
      pos_ge_q <= position_i >= open_stop_q;
      diff_q   <= diff_in;
      ws_q     <= ws_in;
    end
  end

  assign in_stall_o   = state_q != ST_IDLE;
  assign out_valid_o  = out_valid_q;
  assign finger_out_o = finger_out_q;
  assign velocity_o   = velocity_q;

endmodule
